@@ rtl/chb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_pkg
// types, codes and byte classifiers shared by the chunked body decoder
// ----------------------------------------------------------------------------
package chb_pkg;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_start;
    } t_in;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] kind;
        logic       chunk_last;
    } t_out;

    typedef enum logic [2:0] {
        PH_LINE    = 3'd0,
        PH_LINE_CR = 3'd1,
        PH_DATA    = 3'd2,
        PH_SKIP    = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [1:0] TRAILER_LEN = 2'd2;

    // bit 4 set when the byte is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            v = {1'b1, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

endpackage

@@ rtl/chb_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_parser
// parser state and one-byte step: size line, payload pass, trailer skip
// ----------------------------------------------------------------------------
module chb_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  chb_pkg::t_in  i_req,
    output logic          o_res_valid,
    output chb_pkg::t_out o_res
);
    import chb_pkg::*;

    typedef struct packed {
        logic [SIZE_BITS-1:0] acc;
        logic                 seen;
        logic                 stopped;
        logic                 ovf;
    } t_line;

    t_phase               r_phase, n_phase, c_phase;
    t_line                r_line, n_line, c_line;
    logic [SIZE_BITS-1:0] r_left, n_left, c_left, dec_left;
    logic [1:0]           r_skip, n_skip, c_skip, dec_skip;
    t_line                cr_line;
    logic [7:0]           b;

    function automatic t_line line_step(input t_line s, input logic [7:0] ch);
        t_line      t;
        logic [4:0] hv;
        t  = s;
        hv = hex_value(ch);
        if (!s.stopped) begin
            if (hv[4]) begin
                if (s.acc[SIZE_BITS-1 -: 4] != 4'd0) begin
                    t.ovf     = 1'b1;
                    t.stopped = 1'b1;
                end else begin
                    t.acc  = {s.acc[SIZE_BITS-5:0], hv[3:0]};
                    t.seen = 1'b1;
                end
            end else if (!(!s.seen && is_space(ch))) begin
                t.stopped = 1'b1;
            end
        end
        return t;
    endfunction

    assign b = i_req.body_byte;

    // a new body clears everything before the byte is used
    always_comb begin
        if (i_req.body_start) begin
            c_phase = PH_LINE;
            c_line  = '0;
            c_left  = '0;
            c_skip  = '0;
        end else begin
            c_phase = r_phase;
            c_line  = r_line;
            c_left  = r_left;
            c_skip  = r_skip;
        end
    end

    assign dec_left = c_left - SIZE_BITS'(1);
    assign dec_skip = (c_skip != 2'd0) ? c_skip - 2'd1 : 2'd0;
    // a held cr that turns out not to start cr lf is line content
    assign cr_line  = line_step(c_line, CH_CR);

    always_comb begin
        n_phase = c_phase;
        n_line  = c_line;
        n_left  = c_left;
        n_skip  = c_skip;
        unique case (c_phase)
            PH_LINE: begin
                if (b == CH_CR) begin
                    n_phase = PH_LINE_CR;
                end else begin
                    n_line = line_step(c_line, b);
                end
            end
            PH_LINE_CR: begin
                if (b == CH_LF) begin
                    if (!c_line.seen || c_line.ovf || c_line.acc == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_left  = c_line.acc;
                        n_phase = PH_DATA;
                    end
                end else if (b == CH_CR) begin
                    n_line = cr_line;
                end else begin
                    n_line  = line_step(cr_line, b);
                    n_phase = PH_LINE;
                end
            end
            PH_DATA: begin
                n_left = dec_left;
                if (dec_left == '0) begin
                    n_phase = PH_SKIP;
                    n_skip  = TRAILER_LEN;
                end
            end
            PH_SKIP: begin
                n_skip = dec_skip;
                if (dec_skip == 2'd0) begin
                    n_phase = PH_LINE;
                    n_line  = '0;
                end
            end
            default: begin
                n_phase = c_phase;
            end
        endcase
    end

    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (c_phase)
            PH_LINE_CR: begin
                if (b == CH_LF) begin
                    if (!c_line.seen || c_line.ovf) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_ERR;
                    end else if (c_line.acc == '0) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_END;
                    end
                end
            end
            PH_DATA: begin
                o_res_valid      = 1'b1;
                o_res.data_byte  = b;
                o_res.kind       = KIND_DATA;
                o_res.chunk_last = (dec_left == '0);
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE;
            r_line  <= '0;
            r_left  <= '0;
            r_skip  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_left  <= n_left;
            r_skip  <= n_skip;
        end
    end

endmodule

@@ rtl/chb_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_out_reg
// result register holding one result until the consumer takes it
// ----------------------------------------------------------------------------
module chb_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  chb_pkg::t_out i_res,
    input  logic          i_stall,
    output logic          o_valid,
    output logic          o_busy,
    output chb_pkg::t_out o_res
);
    import chb_pkg::*;

    logic r_valid;
    t_out r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_busy  = r_valid && i_stall;
    assign o_res   = r_res;

endmodule

@@ rtl/http_chunked_body_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// decodes an http chunked body one byte per cycle into payload bytes
// ----------------------------------------------------------------------------
// Takes one body byte per clock and answers each with zero or one result in
// the next cycle: a payload byte (chunk_last marks the end of a chunk), an end
// marker after a zero-size line, or an error for a size line without hex
// digits or wider than SIZE_BITS. Size lines and the two bytes after each
// chunk give no result. Throughput is one byte per cycle, set by the single
// step from the parser state registers to the result register; the input
// stalls only while the result register is full and its consumer stalls.
// After an end marker or an error, bytes are dropped until body_start.
module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  chb_pkg::t_in  i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output chb_pkg::t_out o_res
);
    import chb_pkg::*;

    logic accept;
    logic res_valid;
    logic busy;
    t_out res;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    chb_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    chb_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_busy  (busy),
        .o_res   (o_res)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chunked body decoder unit
// ----------------------------------------------------------------------------
// Body bytes are sent as requests with random gaps, and results are taken
// with random stalls. A behavioral decoder in the bench tracks the parser
// state for every accepted request and queues the result that it should
// cause. Each accepted result is checked field by field against the oldest
// queued one. Directed bodies cover the corner cases of the size line. They
// are followed by random noise and by mostly well-formed random bodies.
// ----------------------------------------------------------------------------
module tb_top;
    import chb_pkg::*;

    localparam int SIZE_BITS    = 32;
    localparam int RANDOM_ITEMS = 580;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_out o_res;

    http_chunked_body_decoder_unit #(
        .SIZE_BITS(SIZE_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (o_res)
    );

    always #10 i_clk = ~i_clk;

    // decoder state kept by the bench
    t_phase               st_phase       = PH_LINE;
    logic [SIZE_BITS-1:0] st_size        = '0;
    logic                 st_have_digit  = 1'b0;
    logic                 st_digits_done = 1'b0;
    logic                 st_too_big     = 1'b0;
    logic [SIZE_BITS-1:0] st_remaining   = '0;
    logic [1:0]           st_trailer     = '0;

    t_out expected_results[$];
    int   mismatches    = 0;
    int   sent_count    = 0;
    bit   start_pending = 1'b0;
    bit   tx_steady     = 1'b0;
    int   rx_left       = 0;

    function automatic void size_line_reset();
        st_phase       = PH_LINE;
        st_size        = '0;
        st_have_digit  = 1'b0;
        st_digits_done = 1'b0;
        st_too_big     = 1'b0;
    endfunction

    function automatic void take_line_char(input logic [7:0] b);
        logic       is_hex;
        logic [3:0] nib;
        is_hex = 1'b1;
        nib    = 4'd0;
        if (st_digits_done) return;
        if (b >= "0" && b <= "9") begin
            nib = 4'(b - 8'h30);
        end else if (b >= "a" && b <= "f") begin
            nib = 4'(b - 8'h57);
        end else if (b >= "A" && b <= "F") begin
            nib = 4'(b - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
        if (is_hex) begin
            // one more digit would push bits out of the top
            if (st_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                st_too_big     = 1'b1;
                st_digits_done = 1'b1;
            end else begin
                st_size       = {st_size[SIZE_BITS-5:0], nib};
                st_have_digit = 1'b1;
            end
        end else if (!st_have_digit && (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))) begin
            // leading white space
        end else begin
            st_digits_done = 1'b1;
        end
    endfunction

    function automatic bit decode_step(input t_in req, output t_out res);
        logic [7:0] b;
        bit         has;
        b   = req.body_byte;
        res = '0;
        has = 1'b0;
        if (req.body_start) begin
            size_line_reset();
            st_remaining = '0;
            st_trailer   = '0;
        end
        case (st_phase)
            PH_LINE: begin
                if (b == CH_CR) st_phase = PH_LINE_CR;
                else take_line_char(b);
            end
            PH_LINE_CR: begin
                if (b == CH_LF) begin
                    if (!st_have_digit || st_too_big) begin
                        st_phase = PH_DONE;
                        res.kind = KIND_ERR;
                        has      = 1'b1;
                    end else if (st_size == '0) begin
                        st_phase = PH_DONE;
                        res.kind = KIND_END;
                        has      = 1'b1;
                    end else begin
                        st_remaining = st_size;
                        st_phase     = PH_DATA;
                    end
                end else begin
                    // a cr without lf is part of the line
                    take_line_char(CH_CR);
                    if (b != CH_CR) begin
                        take_line_char(b);
                        st_phase = PH_LINE;
                    end
                end
            end
            PH_DATA: begin
                st_remaining  = st_remaining - SIZE_BITS'(1);
                res.data_byte = b;
                res.kind      = KIND_DATA;
                has           = 1'b1;
                if (st_remaining == '0) begin
                    st_phase       = PH_SKIP;
                    st_trailer     = TRAILER_LEN;
                    res.chunk_last = 1'b1;
                end
            end
            PH_SKIP: begin
                if (st_trailer > 2'd0) st_trailer = st_trailer - 2'd1;
                if (st_trailer == 2'd0) size_line_reset();
            end
            default: begin
            end
        endcase
        return has;
    endfunction

    // result side: take and check results, stall at random
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: data %h kind %0d last %0d",
                             o_res.data_byte, o_res.kind, o_res.chunk_last);
            end else begin
                want = expected_results.pop_front();
                if (o_res.data_byte !== want.data_byte || o_res.kind !== want.kind ||
                    o_res.chunk_last !== want.chunk_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp data %h kind %0d last %0d, got %h %0d %0d",
                                 want.data_byte, want.kind, want.chunk_last,
                                 o_res.data_byte, o_res.kind, o_res.chunk_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int pick;
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                i_stall <= 1'b0;
                rx_left <= $urandom_range(0, 40);
            end else if (pick < 92) begin
                i_stall <= 1'b1;
                rx_left <= $urandom_range(0, 3);
            end else begin
                i_stall <= 1'b1;
                rx_left <= $urandom_range(5, 30);
            end
        end
    end

    function automatic int tx_pause();
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_steady || pick < 70) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        t_in  req;
        t_out res;
        int   gap;
        req.body_byte  = b;
        req.body_start = start_pending;
        start_pending  = 1'b0;
        gap = tx_pause();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        if (decode_step(req, res)) expected_results.insert(expected_results.size(), res);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic begin_body();
        start_pending = 1'b1;
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        if ($urandom_range(0, 1)) return 8'h57 + nib;
        return 8'h37 + nib;
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    task automatic send_hex_size(input logic [SIZE_BITS-1:0] sz);
        int ndig;
        ndig = 1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte(space_char());
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_byte("0");
        for (int i = SIZE_BITS / 4 - 1; i > 0; i--) begin
            if (sz[i*4 +: 4] != 4'd0) begin
                ndig = i + 1;
                break;
            end
        end
        for (int i = ndig - 1; i >= 0; i--) send_byte(hex_char(sz[i*4 +: 4]));
    endtask

    task automatic send_line_end();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_byte(";");
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 35) begin
            // stray cr inside the line, not followed by lf
            send_byte(CH_CR);
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_random_body();
        int nchunks;
        int sz;
        int cut;
        int pick;
        begin_body();
        nchunks = $urandom_range(0, 3);
        for (int c = 0; c < nchunks; c++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) sz = $urandom_range(1, 6);
            else if (pick < 95) sz = $urandom_range(7, 40);
            else sz = $urandom_range(41, 120);
            send_hex_size(sz);
            send_line_end();
            cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, sz - 1) : sz;
            for (int k = 0; k < cut; k++) send_byte(8'($urandom_range(0, 255)));
            // body cut short, the next body restarts the parser
            if (cut < sz) return;
            if ($urandom_range(0, 4) != 0) begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end else begin
                repeat (2) send_byte(8'($urandom_range(0, 255)));
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            send_hex_size('0);
            send_line_end();
        end else if (pick < 86) begin
            send_byte(hex_char(4'($urandom_range(1, 15))));
            repeat (SIZE_BITS / 4) send_byte(hex_char(4'($urandom_range(0, 15))));
            send_line_end();
        end else if (pick < 93) begin
            case ($urandom_range(0, 3))
                0: send_byte("+");
                1: send_byte("-");
                2: send_byte("g");
                default: ;
            endcase
            send_line_end();
        end else begin
            repeat ($urandom_range(0, 2)) send_byte(hex_char(4'($urandom_range(0, 15))));
            return;
        end
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_basic_chunks();
        begin_body();
        send_text(" \t2;e\015\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("\015\n0\015\nz");
    endtask

    task automatic test_cr_and_prefixes();
        // lone cr as leading space, then as a stop character
        begin_body();
        send_text("\0151\015\015\n");
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'h80);
        // 0x prefix reads as zero, so this is the end marker
        send_text("0x9\015\n");
    endtask

    task automatic test_size_limits();
        begin_body();
        send_text("FFFFFFFF\015\n");
        send_byte(8'h5A);
        // restart in the middle of a huge chunk
        begin_body();
        send_text("-5\015\n");
        begin_body();
        send_text("1ffffffff\015\n");
        begin_body();
        send_text("\015\n");
    endtask

    task automatic test_noise();
        for (int i = 0; i < 60; i++) begin
            start_pending = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 3))
                0: send_byte(8'($urandom_range(0, 255)));
                1: send_byte(($urandom_range(0, 1)) ? CH_CR : CH_LF);
                2: send_byte(hex_char(4'($urandom_range(0, 2))));
                default: send_byte(space_char());
            endcase
        end
    endtask

    task automatic test_random_bodies();
        int first_count;
        int bodies;
        first_count = sent_count;
        bodies      = 0;
        while (sent_count - first_count < RANDOM_ITEMS) begin
            tx_steady = ($urandom_range(0, 5) == 0);
            send_random_body();
            bodies++;
            // hold the next request until the result queue runs dry
            if (bodies % 25 == 12) wait_all_results();
        end
        tx_steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_chunks();
        test_cr_and_prefixes();
        test_size_limits();
        test_noise();
        test_random_bodies();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/chb_pkg.sv
rtl/chb_parser.sv
rtl/chb_out_reg.sv
rtl/http_chunked_body_decoder_unit.sv
tb/tb_top.sv
